// ===== hw/rtl/mser_pkg.sv =====
// ----------------------------------------------------------------------------
// mser_pkg: shared types and constants of the multi-sonar echo ranger
// Register map, reset values, field widths and the cm scaling constants.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package mser_pkg;

	localparam int NumSonars = 3;

	localparam int EchoW   = 3;
	localparam int SonarW  = 2;
	localparam int DistW   = 12;
	localparam int CountW  = 17;
	localparam int TrigW   = 8;
	localparam int GapW    = 16;
	localparam int CfgIdxW = 3;
	localparam int CfgDataW = 17;

	// register indexes
	localparam logic [CfgIdxW-1:0] RegTriggerHigh = 3'd0;
	localparam logic [CfgIdxW-1:0] RegEchoTimeout = 3'd1;
	localparam logic [CfgIdxW-1:0] RegMaxEcho     = 3'd2;
	localparam logic [CfgIdxW-1:0] RegOutOfRange  = 3'd3;
	localparam logic [CfgIdxW-1:0] RegGap         = 3'd4;

	// reset values
	localparam logic [TrigW-1:0]  RstTriggerHigh = 8'd10;
	localparam logic [CountW-1:0] RstEchoTimeout = 17'd100000;
	localparam logic [CountW-1:0] RstMaxEcho     = 17'd38000;
	localparam logic [DistW-1:0]  RstOutOfRange  = 12'd5;
	localparam logic [GapW-1:0]   RstGap         = 16'd1000;

	// ticks of trigger low before each trigger pulse
	localparam logic [CountW-1:0] PreLowTicks = 17'd2;

	// width*34/2000 == floor(width * CmMul / 2^CmShift) for any 17-bit width
	localparam int CmMulW  = 24;
	localparam int CmShift = 29;
	localparam logic [CmMulW-1:0] CmMul = 24'd9126807;
	localparam int CmProdW = CountW + CmMulW;

	typedef struct packed {
		logic [TrigW-1:0]  trigger_high_ticks;
		logic [CountW-1:0] echo_timeout_ticks;
		logic [CountW-1:0] max_echo_ticks;
		logic [DistW-1:0]  out_of_range_value;
		logic [GapW-1:0]   gap_ticks;
	} cfg_t;

endpackage

`default_nettype wire

// ===== hw/rtl/mser_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// mser_cfg_regs: configuration register file
// Five registers written by index; unknown indexes are dropped.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mser_cfg_regs (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           wr_en,
	input  wire logic [mser_pkg::CfgIdxW-1:0]  wr_index,
	input  wire logic [mser_pkg::CfgDataW-1:0] wr_data,
	output mser_pkg::cfg_t                      cfg
);
	import mser_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.trigger_high_ticks <= RstTriggerHigh;
			cfg_q.echo_timeout_ticks <= RstEchoTimeout;
			cfg_q.max_echo_ticks     <= RstMaxEcho;
			cfg_q.out_of_range_value <= RstOutOfRange;
			cfg_q.gap_ticks          <= RstGap;
		end else if (wr_en) begin
			case (wr_index)
				RegTriggerHigh: cfg_q.trigger_high_ticks <= wr_data[TrigW-1:0];
				RegEchoTimeout: cfg_q.echo_timeout_ticks <= wr_data[CountW-1:0];
				RegMaxEcho:     cfg_q.max_echo_ticks     <= wr_data[CountW-1:0];
				RegOutOfRange:  cfg_q.out_of_range_value <= wr_data[DistW-1:0];
				RegGap:         cfg_q.gap_ticks          <= wr_data[GapW-1:0];
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

// ===== hw/rtl/multi_sonar_echo_ranger.sv =====
// ----------------------------------------------------------------------------
// multi_sonar_echo_ranger: round-robin ultrasonic ranging controller
// Path: each tick passes the input reg, then the result reg.
// Throughput: one tick per cycle unless report_stall holds the result reg.
// Reset: sonar 0 in pre-trigger low, counters zero, registers at defaults.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module multi_sonar_echo_ranger #(
	parameter int NUM_SONARS = mser_pkg::NumSonars
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	// tick channel
	input  wire logic                           tick_valid,
	output logic                                tick_stall,
	input  wire logic [mser_pkg::EchoW-1:0]     echo_levels,
	// report channel
	output logic                                report_valid,
	input  wire logic                           report_stall,
	output logic [mser_pkg::EchoW-1:0]          trigger_levels,
	output logic                                result_valid,
	output logic [mser_pkg::SonarW-1:0]         sonar_index,
	output logic [mser_pkg::DistW-1:0]          distance_cm,
	output logic                                round_done,
	// configuration
	input  wire logic                           cfg_valid,
	output logic                                cfg_ready,
	input  wire logic [mser_pkg::CfgIdxW-1:0]   cfg_index,
	input  wire logic [mser_pkg::CfgDataW-1:0]  cfg_data
);
	import mser_pkg::*;

	localparam logic [2:0] PhPreLow   = 3'd0;
	localparam logic [2:0] PhTrigHigh = 3'd1;
	localparam logic [2:0] PhWaitRise = 3'd2;
	localparam logic [2:0] PhMeasure  = 3'd3;
	localparam logic [2:0] PhGap      = 3'd4;

	localparam logic [SonarW-1:0] LastSonar = SonarW'(NUM_SONARS - 1);

	cfg_t cfg;

	assign cfg_ready = 1'b1;

	mser_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid && cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	// ---------------- input register
	logic             valid_s1;
	logic [EchoW-1:0] echo_s1;
	logic             adv_out;
	logic             fire;

	assign adv_out    = !report_valid || !report_stall;
	assign tick_stall = valid_s1 && !adv_out;
	assign fire       = valid_s1 && adv_out;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!tick_stall) begin
			valid_s1 <= tick_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (tick_valid && !tick_stall) begin
			echo_s1 <= echo_levels;
		end
	end

	// ---------------- ranging state
	logic [2:0]        phase_q, phase_d;
	logic [SonarW-1:0] sonar_q, sonar_d;
	logic [CountW-1:0] cnt_q, cnt_d;
	logic [CountW-1:0] width_q, width_d;

	logic [CountW-1:0] cnt_inc;
	logic [CountW-1:0] width_inc;
	logic [TrigW-1:0]  trig_lim;
	logic [CountW-1:0] tmo_lim;
	logic [SonarW-1:0] sonar_next;
	logic [EchoW-1:0]  sonar_onehot;
	logic              echo_bit;
	logic [CountW-1:0] meas_w;
	logic [CmProdW-1:0] cm_prod;
	logic [DistW-1:0]  meas_cm;

	logic              fin;
	logic [DistW-1:0]  fin_dist;
	logic [EchoW-1:0]  trig_d;

	assign cnt_inc      = cnt_q + CountW'(1);
	assign width_inc    = width_q + CountW'(1);
	assign trig_lim     = (cfg.trigger_high_ticks == '0) ? TrigW'(1) : cfg.trigger_high_ticks;
	assign tmo_lim      = (cfg.echo_timeout_ticks == '0) ? CountW'(1) : cfg.echo_timeout_ticks;
	assign sonar_next   = (sonar_q == LastSonar) ? '0 : sonar_q + SonarW'(1);
	assign sonar_onehot = EchoW'(1) << sonar_q;
	assign echo_bit     = echo_s1[sonar_q];

	// width at completion: this tick counts only while the echo is still high
	assign meas_w  = echo_bit ? width_inc : width_q;
	assign cm_prod = CmProdW'(meas_w) * CmProdW'(CmMul);
	assign meas_cm = (meas_w >= cfg.max_echo_ticks) ? cfg.out_of_range_value
	                                                : cm_prod[CmShift +: DistW];

	always_comb begin
		phase_d  = phase_q;
		sonar_d  = sonar_q;
		cnt_d    = cnt_q;
		width_d  = width_q;
		trig_d   = '0;
		fin      = 1'b0;
		fin_dist = '0;
		case (phase_q)
			PhTrigHigh: begin
				trig_d = sonar_onehot;
				cnt_d  = cnt_inc;
				if (cnt_inc >= CountW'(trig_lim)) begin
					phase_d = PhWaitRise;
					cnt_d   = '0;
				end
			end
			PhWaitRise: begin
				if (echo_bit) begin
					phase_d = PhMeasure;
					cnt_d   = '0;
					width_d = '0;
				end else begin
					cnt_d = cnt_inc;
					// missed rise reports zero distance
					if (cnt_inc >= tmo_lim) begin
						fin = 1'b1;
					end
				end
			end
			PhMeasure: begin
				if (!echo_bit) begin
					fin      = 1'b1;
					fin_dist = meas_cm;
				end else begin
					width_d = width_inc;
					if (width_inc >= tmo_lim) begin
						fin      = 1'b1;
						fin_dist = meas_cm;
					end
				end
			end
			PhGap: begin
				cnt_d = cnt_inc;
				if (cnt_inc >= CountW'(cfg.gap_ticks)) begin
					sonar_d = sonar_next;
					phase_d = PhPreLow;
					cnt_d   = '0;
				end
			end
			PhPreLow: begin
				cnt_d = cnt_inc;
				if (cnt_inc >= PreLowTicks) begin
					phase_d = PhTrigHigh;
					cnt_d   = '0;
				end
			end
			default: begin
				phase_d = PhPreLow;
				cnt_d   = CountW'(1);
				width_d = '0;
			end
		endcase

		if (fin) begin
			cnt_d   = '0;
			width_d = '0;
			if (cfg.gap_ticks == '0) begin
				sonar_d = sonar_next;
				phase_d = PhPreLow;
			end else begin
				phase_d = PhGap;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PhPreLow;
			sonar_q <= '0;
			cnt_q   <= '0;
			width_q <= '0;
		end else if (fire) begin
			phase_q <= phase_d;
			sonar_q <= sonar_d;
			cnt_q   <= cnt_d;
			width_q <= width_d;
		end
	end

	// ---------------- result register
	logic              report_valid_q;
	logic [EchoW-1:0]  trigger_levels_q;
	logic              result_valid_q;
	logic [SonarW-1:0] sonar_index_q;
	logic [DistW-1:0]  distance_cm_q;
	logic              round_done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			report_valid_q <= 1'b0;
		end else if (adv_out) begin
			report_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			trigger_levels_q <= trig_d;
			result_valid_q   <= fin;
			sonar_index_q    <= fin ? sonar_q : '0;
			distance_cm_q    <= fin_dist;
			round_done_q     <= fin && (sonar_q == LastSonar);
		end
	end

	assign report_valid   = report_valid_q;
	assign trigger_levels = trigger_levels_q;
	assign result_valid   = result_valid_q;
	assign sonar_index    = sonar_index_q;
	assign distance_cm    = distance_cm_q;
	assign round_done     = round_done_q;

`ifndef SYNTHESIS
	a_trig_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		report_valid |-> $onehot0(trigger_levels))
		else $error("trigger drives more than one sonar");

	a_idle_fields_zero: assert property (@(posedge clk) disable iff (!arst_n)
		report_valid && !result_valid |->
			sonar_index == '0 && distance_cm == '0 && !round_done)
		else $error("result fields set without a result");

	a_round_done_last: assert property (@(posedge clk) disable iff (!arst_n)
		report_valid && round_done |-> result_valid && sonar_index == LastSonar)
		else $error("round_done on a sonar other than the last");

	a_no_trig_with_result: assert property (@(posedge clk) disable iff (!arst_n)
		report_valid && result_valid |-> trigger_levels == '0)
		else $error("trigger high in the tick of a result");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		tick_stall |-> report_valid && report_stall)
		else $error("tick stalled while result register can advance");
`endif

endmodule

`default_nettype wire
